@@ sv/joystick_axis_conditioner_top_assert.svh @@
// assertion macros shared by the joystick axis conditioner modules
// no dependencies; included by jac_ctrl and jac_datapath
`ifndef JOYSTICK_AXIS_CONDITIONER_TOP_ASSERT_SVH
`define JOYSTICK_AXIS_CONDITIONER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define JAC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define JAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/jac_pkg.sv @@
// types and constants for the joystick axis conditioner
// no dependencies; imported by jac_ctrl, jac_datapath and the top level
package jac_pkg;

	// field widths
	localparam int RAW_W      = 12;
	localparam int CAL_W      = 12;
	localparam int DB_W       = 15;
	localparam int REV_W      = 4;
	localparam int NORM_W     = 16;
	localparam int VEL_W      = 15;
	localparam int TURN_W     = 16;
	localparam int Q_W        = 15;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 15;
	localparam int S_TDATA_W  = 56;
	localparam int M_TDATA_W  = 120;

	// divider geometry: two quotient bits per cycle
	localparam int DIV_W     = 17;
	localparam int QUO_W     = 16;
	localparam int DIV_ITERS = 8;
	localparam int STEP_W    = 3;

	// axis sequencing
	localparam int NUM_AXES = 4;
	localparam int AX_W     = 2;
	localparam logic [AX_W-1:0] AX_LX = 2'd0;
	localparam logic [AX_W-1:0] AX_LY = 2'd1;
	localparam logic [AX_W-1:0] AX_RX = 2'd2;
	localparam logic [AX_W-1:0] AX_RY = 2'd3;

	// fixed-point constants
	localparam logic [Q_W-1:0] Q_MAX = 15'h7fff;
	localparam logic [15:0] Q_ONE = 16'h8000;
	// n/3 == (n * 43691) >> 17 for n below 2^16
	localparam logic [15:0] THIRD_RECIP = 16'd43691;
	localparam int THIRD_SHIFT = 17;

	// configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_CAL_CENTER   = 3'd0,
		REG_CAL_MIN      = 3'd1,
		REG_CAL_MAX      = 3'd2,
		REG_DEAD_BAND    = 3'd3,
		REG_REVERSE_MASK = 3'd4
	} cfg_reg_t;

	// input item, first field in the lowest bits
	typedef struct packed {
		logic [5:0]       pad;
		logic             right_button;
		logic [RAW_W-1:0] right_y_raw;
		logic [RAW_W-1:0] right_x_raw;
		logic             left_button;
		logic [RAW_W-1:0] left_y_raw;
		logic [RAW_W-1:0] left_x_raw;
	} in_item_t;

	// result item, first field in the lowest bits
	typedef struct packed {
		logic [5:0]               pad;
		logic signed [TURN_W-1:0] turn_z;
		logic signed [VEL_W-1:0]  vel_y;
		logic signed [VEL_W-1:0]  vel_x;
		logic                     mode_toggled;
		logic                     drive_mode;
		logic                     right_active;
		logic                     left_active;
		logic signed [NORM_W-1:0] right_y_norm;
		logic signed [NORM_W-1:0] right_x_norm;
		logic signed [NORM_W-1:0] left_y_norm;
		logic signed [NORM_W-1:0] left_x_norm;
	} out_item_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE_INIT,
		ST_SCALE_DIV,
		ST_DZ_INIT,
		ST_DZ_DIV,
		ST_STORE,
		ST_VEL,
		ST_DONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic            load;
		logic            scale_init;
		logic            div_step;
		logic            dz_init;
		logic            store;
		logic            vel;
		logic            out_load;
		logic [AX_W-1:0] axis;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

@@ sv/jac_ctrl.sv @@
// sequencing state machine for the joystick axis conditioner
// depends on jac_pkg and joystick_axis_conditioner_top_assert.svh
`include "joystick_axis_conditioner_top_assert.svh"

module jac_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output jac_pkg::cmd_t cmd,
	input  jac_pkg::sts_t sts
);
	import jac_pkg::*;

	state_t state_q;
	state_t state_d;
	logic [AX_W-1:0] axis_q;
	logic [STEP_W-1:0] step_q;
	logic div_last;
	logic axis_last;

	assign div_last  = (step_q == STEP_W'(DIV_ITERS - 1));
	assign axis_last = (axis_q == AX_W'(NUM_AXES - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:       if (s_tvalid) state_d = ST_SCALE_INIT;
			ST_SCALE_INIT: state_d = ST_SCALE_DIV;
			ST_SCALE_DIV:  if (div_last) state_d = ST_DZ_INIT;
			ST_DZ_INIT:    state_d = ST_DZ_DIV;
			ST_DZ_DIV:     if (div_last) state_d = ST_STORE;
			ST_STORE:      state_d = axis_last ? ST_VEL : ST_SCALE_INIT;
			ST_VEL:        state_d = ST_DONE;
			ST_DONE:       if (sts.out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready       = 1'b0;
		cmd            = '0;
		cmd.axis       = axis_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_SCALE_INIT: cmd.scale_init = 1'b1;
			ST_SCALE_DIV:  cmd.div_step = 1'b1;
			ST_DZ_INIT:    cmd.dz_init = 1'b1;
			ST_DZ_DIV:     cmd.div_step = 1'b1;
			ST_STORE:      cmd.store = 1'b1;
			ST_VEL:        cmd.vel = 1'b1;
			ST_DONE:       cmd.out_load = sts.out_free;
			default:       cmd = '0;
		endcase
	end

	// state, axis and divider step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				axis_q <= '0;
			end else if (cmd.store) begin
				axis_q <= axis_q + AX_W'(1);
			end
			if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	// checks
	`JAC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready,
		"input accepted while a transaction is in progress")
	`JAC_ASSERT_NOW(a_load_needs_room, clk, arst_n, cmd.out_load, sts.out_free,
		"result loaded over an untaken result")
	`JAC_ASSERT_NEXT(a_div_length, clk, arst_n, state_q == ST_SCALE_DIV && div_last,
		state_q == ST_DZ_INIT, "scaling division ran past its step count")

endmodule

@@ sv/jac_datapath.sv @@
// datapath: config registers, shared radix-4 divider, axis results and output register
// depends on jac_pkg and joystick_axis_conditioner_top_assert.svh
`include "joystick_axis_conditioner_top_assert.svh"

module jac_datapath #(
	parameter int ADC_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  jac_pkg::cmd_t                       cmd,
	output jac_pkg::sts_t                       sts,
	input  logic [jac_pkg::S_TDATA_W-1:0]       s_tdata,
	input  logic                                cfg_we,
	input  logic [jac_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [jac_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [jac_pkg::M_TDATA_W-1:0]       m_tdata
);
	import jac_pkg::*;

	localparam logic [RAW_W-1:0] ADC_MASK =
		(ADC_BITS >= RAW_W) ? {RAW_W{1'b1}} : RAW_W'((1 << ADC_BITS) - 1);
	localparam int VMAG_W = 14;
	localparam int PROD_W = 31;

	// configuration registers
	logic [CAL_W-1:0] cal_center_q, cal_min_q, cal_max_q;
	logic [DB_W-1:0]  db_q;
	logic [REV_W-1:0] rev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_center_q <= 12'd2048;
			cal_min_q    <= 12'd0;
			cal_max_q    <= 12'd4095;
			db_q         <= '0;
			rev_q        <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_CAL_CENTER:   cal_center_q <= cfg_wdata[CAL_W-1:0];
				REG_CAL_MIN:      cal_min_q <= cfg_wdata[CAL_W-1:0];
				REG_CAL_MAX:      cal_max_q <= cfg_wdata[CAL_W-1:0];
				REG_DEAD_BAND:    db_q <= cfg_wdata[DB_W-1:0];
				REG_REVERSE_MASK: rev_q <= cfg_wdata[REV_W-1:0];
				default: ;
			endcase
		end
	end

	// input latch and mode tracking
	in_item_t in_q;
	in_item_t in_w;
	logic both_w;
	logic prev_q, mode_q, drive_q, toggled_q;

	assign in_w   = in_item_t'(s_tdata);
	assign both_w = in_w.left_button & in_w.right_button;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q      <= in_w;
			drive_q   <= mode_q;
			toggled_q <= both_w & ~prev_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
			mode_q <= 1'b0;
		end else if (cmd.load) begin
			prev_q <= both_w;
			if (both_w && !prev_q) mode_q <= ~mode_q;
		end
	end

	// deviation and span of the selected axis
	logic [RAW_W-1:0] raw_sel, raw_m, c_m, lo_m, hi_m, dev;
	logic signed [RAW_W:0] span;
	logic neg, span_pos, zero, sat;

	always_comb begin
		case (cmd.axis)
			AX_LX:   raw_sel = in_q.left_x_raw;
			AX_LY:   raw_sel = in_q.left_y_raw;
			AX_RX:   raw_sel = in_q.right_x_raw;
			AX_RY:   raw_sel = in_q.right_y_raw;
			default: raw_sel = in_q.left_x_raw;
		endcase
	end

	assign raw_m    = raw_sel & ADC_MASK;
	assign c_m      = cal_center_q & ADC_MASK;
	assign lo_m     = cal_min_q & ADC_MASK;
	assign hi_m     = cal_max_q & ADC_MASK;
	assign neg      = raw_m < c_m;
	assign dev      = neg ? (c_m - raw_m) : (raw_m - c_m);
	assign span     = neg ? $signed({1'b0, c_m} - {1'b0, lo_m})
	                      : $signed({1'b0, hi_m} - {1'b0, c_m});
	assign span_pos = !span[RAW_W] && (span != '0);
	assign zero     = (dev == '0);
	// quotient reaches full scale when dev is nonzero and the span is degenerate or dev >= span
	assign sat      = !zero && (!span_pos || ({1'b0, dev} >= $unsigned(span)));

	// shared divider, two restoring steps per cycle
	logic [DIV_W-1:0] rem_q, div_q;
	logic [QUO_W-1:0] quo_q;
	logic [DIV_W-1:0] r1, r1s, r2, r2s;
	logic b1, b2;
	logic [Q_W-1:0] quo_mag;

	assign r1      = {rem_q[DIV_W-2:0], 1'b0};
	assign b1      = r1 >= div_q;
	assign r1s     = b1 ? (r1 - div_q) : r1;
	assign r2      = {r1s[DIV_W-2:0], 1'b0};
	assign b2      = r2 >= div_q;
	assign r2s     = b2 ? (r2 - div_q) : r2;
	// sixteen quotient bits of rem*2^16/div, halved for the Q1.15 scale
	assign quo_mag = quo_q[QUO_W-1:1];

	// deadzone decision on the scaled magnitude
	logic neg_q, sat_q, zero_q, dz_q;
	logic [NUM_AXES-1:0] act_q;
	logic [Q_W-1:0] mag;
	logic act;

	assign mag = zero_q ? '0 : (sat_q ? Q_MAX : quo_mag);
	assign act = mag >= db_q;

	always_ff @(posedge clk) begin
		if (cmd.scale_init) begin
			neg_q  <= neg;
			sat_q  <= sat;
			zero_q <= zero;
			quo_q  <= '0;
			if (sat || zero) begin
				rem_q <= '0;
				div_q <= DIV_W'(1);
			end else begin
				rem_q <= DIV_W'(dev);
				div_q <= DIV_W'($unsigned(span));
			end
		end else if (cmd.dz_init) begin
			act_q[cmd.axis] <= act;
			dz_q            <= !act;
			quo_q           <= '0;
			if (act) begin
				rem_q <= DIV_W'(mag - db_q);
				div_q <= DIV_W'(Q_ONE - {1'b0, db_q});
			end else begin
				rem_q <= '0;
				div_q <= DIV_W'(1);
			end
		end else if (cmd.div_step) begin
			rem_q <= r2s;
			quo_q <= {quo_q[QUO_W-3:0], b1, b2};
		end
	end

	// signed axis result with reverse mask
	logic signed [NORM_W-1:0] axv_q [NUM_AXES];
	logic signed [NORM_W-1:0] v_pos;
	logic flip;

	assign v_pos = $signed({1'b0, (dz_q ? {Q_W{1'b0}} : quo_mag)});
	assign flip  = neg_q ^ rev_q[cmd.axis];

	always_ff @(posedge clk) begin
		if (cmd.store) axv_q[cmd.axis] <= flip ? -v_pos : v_pos;
	end

	// velocity magnitudes: divide by three via reciprocal, by two via shift
	logic [NORM_W-1:0] lx_abs, ly_abs, ry_abs;
	logic [PROD_W-1:0] px, py;
	logic [VMAG_W-1:0] vx_mag_q, vy_mag_q, tz_mag_q;
	logic vx_neg_q, vy_neg_q, tz_neg_q;

	assign lx_abs = axv_q[AX_LX][NORM_W-1] ? NORM_W'(-axv_q[AX_LX]) : NORM_W'(axv_q[AX_LX]);
	assign ly_abs = axv_q[AX_LY][NORM_W-1] ? NORM_W'(-axv_q[AX_LY]) : NORM_W'(axv_q[AX_LY]);
	assign ry_abs = axv_q[AX_RY][NORM_W-1] ? NORM_W'(-axv_q[AX_RY]) : NORM_W'(axv_q[AX_RY]);
	assign px     = PROD_W'(lx_abs[Q_W-1:0]) * PROD_W'(THIRD_RECIP);
	assign py     = PROD_W'(ly_abs[Q_W-1:0]) * PROD_W'(THIRD_RECIP);

	always_ff @(posedge clk) begin
		if (cmd.vel) begin
			vx_mag_q <= px[THIRD_SHIFT +: VMAG_W];
			vy_mag_q <= py[THIRD_SHIFT +: VMAG_W];
			tz_mag_q <= ry_abs[Q_W-1:1];
			vx_neg_q <= !axv_q[AX_LX][NORM_W-1];
			vy_neg_q <= axv_q[AX_LY][NORM_W-1];
			tz_neg_q <= !axv_q[AX_RY][NORM_W-1];
		end
	end

	// result assembly
	out_item_t out_w, out_q;
	logic signed [VEL_W-1:0]  vx_ext, vy_ext;
	logic signed [TURN_W-1:0] tz_ext;

	assign vx_ext = $signed({1'b0, vx_mag_q});
	assign vy_ext = $signed({1'b0, vy_mag_q});
	assign tz_ext = $signed({2'b00, tz_mag_q});

	always_comb begin
		out_w              = '0;
		out_w.left_x_norm  = axv_q[AX_LX];
		out_w.left_y_norm  = axv_q[AX_LY];
		out_w.right_x_norm = axv_q[AX_RX];
		out_w.right_y_norm = axv_q[AX_RY];
		out_w.left_active  = act_q[AX_LX] | act_q[AX_LY];
		out_w.right_active = act_q[AX_RX] | act_q[AX_RY];
		out_w.drive_mode   = drive_q;
		out_w.mode_toggled = toggled_q;
		if (drive_q) begin
			out_w.vel_x  = vx_neg_q ? -vx_ext : vx_ext;
			out_w.vel_y  = vy_neg_q ? -vy_ext : vy_ext;
			out_w.turn_z = tz_neg_q ? -tz_ext : tz_ext;
		end
	end

	// output register, one transaction deep
	logic out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) out_q <= out_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || m_tready;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_q;

	// checks
	`JAC_ASSERT_NOW(a_rem_below_div, clk, arst_n, cmd.div_step, rem_q < div_q,
		"divider remainder not below divisor")
	`JAC_ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.out_load, m_tvalid,
		"loaded result not presented")
	`JAC_ASSERT_NOW(a_arm_no_vel, clk, arst_n, m_tvalid && !out_q.drive_mode,
		out_q.vel_x == '0 && out_q.vel_y == '0 && out_q.turn_z == '0,
		"velocity nonzero in arm control mode")

endmodule

@@ sv/joystick_axis_conditioner_top.sv @@
// top level of the joystick axis conditioner
// depends on jac_pkg, jac_ctrl and jac_datapath
//
// usage:
//   s_* carries one transaction per tick: four raw stick samples and two switches.
//   m_* returns one transaction per input: conditioned Q1.15 axes, active flags,
//   mode flags and drive velocities.
//   cfg_we/cfg_addr/cfg_wdata write calibration, deadzone and reverse mask; write
//   only while the block is idle.
// timing:
//   a new item is taken only after the last result has been loaded into the output register;
//   the four axes share one divider retiring two quotient bits per cycle, and each axis needs
//   a setup step, a scaling division, a setup step, a deadzone division and a store step.
//   the output register holds a finished result while the next item is taken in;
//   a stalled receiver holds the block in its final step until the result leaves.
// reset:
//   arst_n clears the handshakes, mode (arm control), switch history and loads
//   the default calibration; no result is pending afterwards.
module joystick_axis_conditioner_top #(
	parameter int ADC_BITS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// left_x_raw, left_y_raw, left_button, right_x_raw, right_y_raw, right_button, zero pad
	input  logic [jac_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// left_x_norm, left_y_norm, right_x_norm, right_y_norm, left_active, right_active,
	// drive_mode, mode_toggled, vel_x, vel_y, turn_z, zero pad
	output logic [jac_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                           cfg_we,
	input  logic [jac_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [jac_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import jac_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	jac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// arithmetic and storage
	jac_datapath #(
		.ADC_BITS (ADC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
